>>> rtl/atb_pkg.sv
// Shared types, constants and tables for the affine transform builder.
// Depends on nothing; every other file imports it.
package atb_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int NSTAGE        = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    localparam int IN_W  = 152;
    localparam int OUT_W = 176;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [18:0] FULL_TURN  = 19'd23040;
    localparam logic [18:0] ROT_OFFSET = 19'd138240;
    localparam logic [14:0] HALF_TURN  = 15'd11520;
    localparam logic [14:0] QUARTER    = 15'd5760;

    typedef logic signed [31:0] atan_tab_t [TAB_LEN];
    localparam atan_tab_t ATAN_TAB = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000233,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    typedef struct packed {
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [14:0]        m;
        logic [1:0]         q;
    } item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [23:0] a;
        logic signed [23:0] b;
        logic signed [23:0] c;
        logic signed [23:0] d;
    } ent_t;

endpackage

>>> rtl/atb_reduce.sv
// Angle reduction: wraps the rotation into one turn, then splits off the quadrant.
// Depends on atb_pkg.
module atb_reduce (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  atb_pkg::item_t       in_item,
    input  logic signed [17:0]   rot,
    output logic                 out_valid,
    output atb_pkg::item_t       out_item,
    output atb_pkg::rot_t        out_rot
);
    import atb_pkg::*;

    logic        v0_reg, v1_reg;
    item_t       item0_reg, item0_next, item1_reg, item1_next;
    rot_t        rot_reg, rot_next;
    logic [18:0] r;
    logic [14:0] rem;

    // conditional subtracts of 8, 4, 2 and 1 turns after a positive offset
    always_comb
    begin
        r = 19'(signed'({rot[17], rot})) + ROT_OFFSET;
        if (r >= (FULL_TURN << 3)) r = r - (FULL_TURN << 3);
        if (r >= (FULL_TURN << 2)) r = r - (FULL_TURN << 2);
        if (r >= (FULL_TURN << 1)) r = r - (FULL_TURN << 1);
        if (r >= FULL_TURN)        r = r - FULL_TURN;
        item0_next   = in_item;
        item0_next.m = r[14:0];
        item0_next.q = 2'd0;
    end

    always_comb
    begin
        item1_next = item0_reg;
        rem        = item0_reg.m;
        if (rem >= HALF_TURN)
        begin
            item1_next.q[1] = 1'b1;
            rem             = rem - HALF_TURN;
        end
        if (rem >= QUARTER)
        begin
            item1_next.q[0] = 1'b1;
            rem             = rem - QUARTER;
        end
        rot_next.x = CORDIC_GAIN;
        rot_next.y = 32'sd0;
        rot_next.z = signed'({4'd0, rem[12:0], 15'd0}) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item0_reg <= item0_next;
            item1_reg <= item1_next;
            rot_reg   <= rot_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_item  = item1_reg;
    assign out_rot   = rot_reg;
endmodule

>>> rtl/atb_cordic_cell.sv
// One CORDIC rotation cell: a micro-rotation by the given shift and angle.
// Depends on atb_pkg.
module atb_cordic_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [4:0]           shift_amt,
    input  logic signed [31:0]   angle,
    input  logic                 in_valid,
    input  atb_pkg::item_t       in_item,
    input  atb_pkg::rot_t        in_rot,
    output logic                 out_valid,
    output atb_pkg::item_t       out_item,
    output atb_pkg::rot_t        out_rot
);
    import atb_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    rot_t  rot_reg, rot_next;
    logic signed [31:0] dx, dy;

    always_comb
    begin
        dx = in_rot.y >>> shift_amt;
        dy = in_rot.x >>> shift_amt;
        if (!in_rot.z[31])
        begin
            rot_next.x = in_rot.x - dx;
            rot_next.y = in_rot.y + dy;
            rot_next.z = in_rot.z - angle;
        end
        else
        begin
            rot_next.x = in_rot.x + dx;
            rot_next.y = in_rot.y - dy;
            rot_next.z = in_rot.z + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            rot_reg  <= rot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rot   = rot_reg;
endmodule

>>> rtl/atb_matrix.sv
// Linear entries: applies the quadrant, scales the sine and cosine, rounds and saturates.
// Depends on atb_pkg.
module atb_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  atb_pkg::item_t       in_item,
    input  atb_pkg::rot_t        in_rot,
    output logic                 out_valid,
    output atb_pkg::item_t       out_item,
    output atb_pkg::ent_t        out_ent
);
    import atb_pkg::*;

    logic  v0_reg, v1_reg;
    item_t item0_reg, item1_reg;
    ent_t  ent_reg, ent_next;
    logic signed [31:0] cs, sn;
    logic signed [47:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [47:0] pa_next, pb_next, pc_next, pd_next;

    function automatic logic signed [23:0] rnd_sat(input logic signed [47:0] p);
        logic signed [47:0] t;
        logic signed [25:0] s;
        t = p + 48'sd2097152;
        s = 26'(t >>> 22);
        if (s > 26'sd8388607)
            return 24'sd8388607;
        else if (s < -26'sd8388608)
            return -24'sd8388608;
        else
            return s[23:0];
    endfunction

    always_comb
    begin
        case (in_item.q)
            2'd0:    begin cs = in_rot.x;  sn = in_rot.y;  end
            2'd1:    begin cs = -in_rot.y; sn = in_rot.x;  end
            2'd2:    begin cs = -in_rot.x; sn = -in_rot.y; end
            default: begin cs = in_rot.y;  sn = -in_rot.x; end
        endcase
        pa_next = 48'(in_item.sx) * 48'(cs);
        pb_next = 48'(in_item.sy) * 48'(-sn);
        pc_next = 48'(in_item.sx) * 48'(sn);
        pd_next = 48'(in_item.sy) * 48'(cs);
        ent_next.a = rnd_sat(pa_reg);
        ent_next.b = rnd_sat(pb_reg);
        ent_next.c = rnd_sat(pc_reg);
        ent_next.d = rnd_sat(pd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item0_reg <= in_item;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            pd_reg    <= pd_next;
            item1_reg <= item0_reg;
            ent_reg   <= ent_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_item  = item1_reg;
    assign out_ent   = ent_reg;
endmodule

>>> rtl/atb_trans.sv
// Translation: origin times the entries, subtracted from the position, rounded to Q.8.
// Depends on atb_pkg.
module atb_trans (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  atb_pkg::item_t       in_item,
    input  atb_pkg::ent_t        in_ent,
    output logic                 out_valid,
    output logic [atb_pkg::OUT_W-1:0] out_data
);
    import atb_pkg::*;

    logic  v0_reg, v1_reg;
    item_t item0_reg;
    ent_t  ent0_reg;
    logic signed [47:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [31:0] tx_next, ty_next;
    logic [OUT_W-1:0]   data_reg, data_next;

    function automatic logic signed [31:0] fin(input logic signed [23:0] p,
                                               input logic signed [47:0] e0,
                                               input logic signed [47:0] e1);
        logic signed [49:0] acc;
        logic signed [33:0] s;
        acc = (50'(p) <<< 16) - (50'(e0) + 50'(e1)) + 50'sd32768;
        s   = 34'(acc >>> 16);
        if (s > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (s < -34'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    always_comb
    begin
        tx_next   = fin(item0_reg.px, p0_reg, p1_reg);
        ty_next   = fin(item0_reg.py, p2_reg, p3_reg);
        data_next = {1'b0, item0_reg.m, ty_next, tx_next,
                     ent0_reg.d, ent0_reg.c, ent0_reg.b, ent0_reg.a};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item0_reg <= in_item;
            ent0_reg  <= in_ent;
            p0_reg    <= 48'(in_item.ox) * 48'(in_ent.a);
            p1_reg    <= 48'(in_item.oy) * 48'(in_ent.b);
            p2_reg    <= 48'(in_item.ox) * 48'(in_ent.c);
            p3_reg    <= 48'(in_item.oy) * 48'(in_ent.d);
            data_reg  <= data_next;
        end
    end

    assign out_valid = v1_reg;
    assign out_data  = data_reg;
endmodule

>>> rtl/affine_transform_builder_core.sv
// Builds a 2x3 affine matrix (scale, clockwise rotation about an origin, then
// position) for every input transaction. One transaction is taken each cycle
// while the output is not stalled. The pipeline is the row of NSTAGE CORDIC cells
// (sixteen here) plus two reduction, two scaling and two translation stages. The
// whole pipeline holds while a finished result waits on m_axis_tready.
module affine_transform_builder_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // origin_x, origin_y, pos_x, pos_y, scale_x, scale_y, rotation_in, zero pad
    input  logic [atb_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // matrix_a, matrix_b, matrix_c, matrix_d, trans_x, trans_y, wrapped_angle, zero pad
    output logic [atb_pkg::OUT_W-1:0] m_axis_tdata
);
    import atb_pkg::*;

    logic  en;
    item_t in_item;
    logic  cv  [NSTAGE+1];
    item_t ci  [NSTAGE+1];
    rot_t  cr  [NSTAGE+1];
    logic  mv;
    item_t mi;
    ent_t  me;

    // advance everything unless the output holds an untaken result
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        in_item.ox = s_axis_tdata[23:0];
        in_item.oy = s_axis_tdata[47:24];
        in_item.px = s_axis_tdata[71:48];
        in_item.py = s_axis_tdata[95:72];
        in_item.sx = s_axis_tdata[111:96];
        in_item.sy = s_axis_tdata[127:112];
        in_item.m  = 15'd0;
        in_item.q  = 2'd0;
    end

    atb_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .rot       (s_axis_tdata[145:128]),
        .out_valid (cv[0]),
        .out_item  (ci[0]),
        .out_rot   (cr[0])
    );

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_cell
        atb_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift_amt (5'(i)),
            .angle     (ATAN_TAB[i]),
            .in_valid  (cv[i]),
            .in_item   (ci[i]),
            .in_rot    (cr[i]),
            .out_valid (cv[i+1]),
            .out_item  (ci[i+1]),
            .out_rot   (cr[i+1])
        );
    end

    atb_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cv[NSTAGE]),
        .in_item   (ci[NSTAGE]),
        .in_rot    (cr[NSTAGE]),
        .out_valid (mv),
        .out_item  (mi),
        .out_ent   (me)
    );

    atb_trans u_trans (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mv),
        .in_item   (mi),
        .in_ent    (me),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );
endmodule

>>> tb/affine_transform_builder_core_test.sv
// Self-checking testbench for affine_transform_builder_core: directed table, then random
// transactions, all checked against a fixed-point transform predictor. Needs atb_pkg.
`timescale 1ns / 100ps

module affine_transform_builder_core_test;

    import atb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int N_RANDOM       = 930;

    typedef struct {
        logic signed [23:0] ox, oy, px, py;
        logic signed [15:0] sx, sy;
        logic signed [17:0] rot;
    } xform_in_t;

    typedef struct {
        logic signed [23:0] a, b, c, d;
        logic signed [31:0] tx, ty;
        logic [14:0]        ang;
    } xform_out_t;

    typedef struct {
        xform_in_t  stim;
        bit         typed;
        logic [14:0] ang;   // typed-in wrapped angle where given
    } table_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;

    xform_out_t matrix_queue[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         stim_done = 0;
    bit         hold_off = 0;
    table_row_t dir_table[$];

    affine_transform_builder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint scale_trig(longint scale, longint trig);
        return clamp(floor_shift(scale * trig + (64'sd1 <<< 21), 22), -8388608, 8388607);
    endfunction

    function automatic longint translate(longint o0, longint e0, longint o1, longint e1,
                                         longint p);
        longint acc;
        acc = p * 65536 - (o0 * e0 + o1 * e1);
        return clamp(floor_shift(acc + 32768, 16), -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic xform_out_t build_matrix(xform_in_t t);
        xform_out_t r;
        longint m, q, z, x, y, dx, dy, cs, sn;
        m = longint'(t.rot) % 23040;
        if (m < 0)
            m += 23040;
        q = m / 5760;
        z = (m - q * 5760) * 65536;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < NSTAGE; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        case (q)
            0: begin cs = x;  sn = y;  end
            1: begin cs = -y; sn = x;  end
            2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        r.a = 24'(scale_trig(t.sx, cs));
        r.b = 24'(scale_trig(t.sy, -sn));
        r.c = 24'(scale_trig(t.sx, sn));
        r.d = 24'(scale_trig(t.sy, cs));
        r.tx = 32'(translate(t.ox, r.a, t.oy, r.b, t.px));
        r.ty = 32'(translate(t.ox, r.c, t.oy, r.d, t.py));
        r.ang = m[14:0];
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_item(xform_in_t t);
        return {6'd0, t.rot, t.sy, t.sx, t.py, t.px, t.oy, t.ox};
    endfunction

    function automatic xform_in_t random_item();
        xform_in_t t;
        int sel;
        sel = $urandom_range(0, 9);
        t.ox = 24'($urandom);
        t.oy = 24'($urandom);
        t.px = 24'($urandom);
        t.py = 24'($urandom);
        t.sx = 16'($urandom);
        t.sy = 16'($urandom);
        t.rot = 18'($urandom);
        // mostly realistic magnitudes so translations stay in range
        if (sel < 6)
        begin
            t.ox = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
            t.oy = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
            t.sx = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            t.sy = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
        end
        if (sel == 9)
            t.rot = 18'($signed(23040 * $signed($urandom_range(0, 10)) - 115200));
        return t;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic add_row(int ox, int oy, int px, int py, int sx, int sy, int rot,
                           int typed, int ang);
        table_row_t r;
        r.stim = '{24'(ox), 24'(oy), 24'(px), 24'(py), 16'(sx), 16'(sy), 18'(rot)};
        r.typed = 1'(typed);
        r.ang = 15'(ang);
        dir_table = {dir_table, r};
    endtask

    task automatic send_item(xform_in_t t, bit typed, logic [14:0] ang);
        xform_out_t e;
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(t);
        do
            @(posedge clk);
        while (!s_axis_tready);
        e = build_matrix(t);
        if (typed && e.ang != ang)
        begin
            $error("wrapped_angle expected %0d actual %0d", ang, e.ang);
            error_count++;
        end
        matrix_queue = {matrix_queue, e};
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        add_row(0, 0, 0, 0, 256, 256, 0, 1, 0);
        add_row(0, 0, 0, 0, 256, 256, 5760, 1, 5760);
        add_row(0, 0, 0, 0, 256, 256, 11520, 1, 11520);
        add_row(0, 0, 0, 0, 256, 256, 17280, 1, 17280);
        add_row(0, 0, 0, 0, 256, 256, 23039, 1, 23039);
        add_row(0, 0, 0, 0, 256, 256, 23040, 1, 0);
        add_row(0, 0, 0, 0, 256, 256, -23040, 1, 0);
        add_row(0, 0, 0, 0, 256, 256, -1, 1, 23039);
        add_row(0, 0, 0, 0, 256, 256, -131072, 1, 7168);
        add_row(0, 0, 0, 0, 256, 256, 131071, 1, 15871);
        add_row(0, 0, 0, 0, -32768, -32768, 11520, 1, 11520);
        add_row(0, 0, 0, 0, 32767, -32768, 0, 1, 0);
        add_row(0, 0, 0, 0, 32767, 32767, 2880, 1, 2880);
        add_row(-8388608, -8388608, 8388607, 8388607, 32767, 32767, 0, 1, 0);
        add_row(8388607, 8388607, -8388608, -8388608, 32767, 32767, 0, 1, 0);
        add_row(8388607, -8388608, 0, 0, -32768, 32767, 5760, 1, 5760);
        add_row(1234, -5678, 100, -200, 300, -400, 1000, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, -1, 1, 23039);
        add_row(256, 512, 0, 0, 512, 256, 7000, 0, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_table[i])
            send_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].ang);
        for (int n = 0; n < N_RANDOM; n++)
            send_item(random_item(), 1'b0, 15'd0);
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls plus one long hold-off while the sender keeps offering
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        repeat (60) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        forever
        begin
            m_axis_tready <= 1'b1;
            @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        xform_out_t got;
        xform_out_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {got.ang, got.ty, got.tx, got.d, got.c, got.b, got.a} = m_axis_tdata[174:0];
            if (matrix_queue.size() == 0)
            begin
                $error("unexpected transaction on result side");
                error_count++;
            end
            else
            begin
                e = matrix_queue.pop_front();
                if (got.a != e.a)
                begin
                    $error("matrix_a expected %0d actual %0d", e.a, got.a);
                    error_count++;
                end
                if (got.b != e.b)
                begin
                    $error("matrix_b expected %0d actual %0d", e.b, got.b);
                    error_count++;
                end
                if (got.c != e.c)
                begin
                    $error("matrix_c expected %0d actual %0d", e.c, got.c);
                    error_count++;
                end
                if (got.d != e.d)
                begin
                    $error("matrix_d expected %0d actual %0d", e.d, got.d);
                    error_count++;
                end
                if (got.tx != e.tx)
                begin
                    $error("trans_x expected %0d actual %0d", e.tx, got.tx);
                    error_count++;
                end
                if (got.ty != e.ty)
                begin
                    $error("trans_y expected %0d actual %0d", e.ty, got.ty);
                    error_count++;
                end
                if (got.ang != e.ang)
                begin
                    $error("wrapped_angle expected %0d actual %0d", e.ang, got.ang);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction, held during the long hold-off
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (!((stim_done && matrix_queue.size() == 0) || idle_cycles >= WATCHDOG_LIMIT))
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (error_count == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end
    end

endmodule
